FILE: rtl/rcls_pkg.sv
package rcls_pkg;

  localparam int unsigned MaxStepsDef = 128;
  localparam int unsigned MaxOpsDef   = 64;
  localparam int unsigned CfgW        = 6;
  localparam int unsigned IdW         = 10;
  localparam int unsigned FreeW       = 8;
  localparam int unsigned StepOutW    = 7;

  localparam logic signed [FreeW-1:0] FreeMin = -8'sd128;

  // free counts of one step, one per unit kind
  typedef struct packed {
    logic signed [FreeW-1:0] add_free;
    logic signed [FreeW-1:0] mul_free;
  } free_pair_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_RES  = 2'd1,
    ST_NO_STEP = 2'd2,
    ST_FULL    = 2'd3
  } sched_status_e;

  typedef enum logic [1:0] {
    CFG_ADD_CNT = 2'd0,
    CFG_MUL_CNT = 2'd1,
    CFG_ADD_LAT = 2'd2,
    CFG_MUL_LAT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEP,
    S_SRCH,
    S_WB
  } seq_state_e;

  // take one unit of the given kind, saturating at the floor
  function automatic free_pair_t take_unit(free_pair_t p, logic kind);
    free_pair_t r;
    r = p;
    if (kind) begin
      if (p.mul_free != FreeMin) r.mul_free = p.mul_free - 8'sd1;
    end else begin
      if (p.add_free != FreeMin) r.add_free = p.add_free - 8'sd1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/rcls_step_cell.sv
module rcls_step_cell import rcls_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            refill_i,
  input  logic [CfgW-1:0] add_cnt_i,
  input  logic [CfgW-1:0] mul_cnt_i,
  input  logic            shift_i,
  input  free_pair_t      nbr_i,
  output free_pair_t      free_o
);

  free_pair_t free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q.add_free <= 8'sd1;
      free_q.mul_free <= 8'sd1;
    end else if (refill_i) begin
      free_q.add_free <= $signed({2'b00, add_cnt_i});
      free_q.mul_free <= $signed({2'b00, mul_cnt_i});
    end else if (shift_i) begin
      free_q <= nbr_i;
    end
  end

  assign free_o = free_q;

endmodule

FILE: rtl/rcls_op_cell.sv
module rcls_op_cell import rcls_pkg::*; #(
  parameter int unsigned FinW = 8
) (
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic            wr_i,
  input  logic [IdW-1:0]  nbr_id_i,
  input  logic [FinW-1:0] nbr_fin_i,
  input  logic [IdW-1:0]  wr_id_i,
  input  logic [FinW-1:0] wr_fin_i,
  output logic [IdW-1:0]  id_o,
  output logic [FinW-1:0] fin_o
);

  logic [IdW-1:0]  id_q;
  logic [FinW-1:0] fin_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      id_q  <= wr_id_i;
      fin_q <= wr_fin_i;
    end else if (shift_i) begin
      id_q  <= nbr_id_i;
      fin_q <= nbr_fin_i;
    end
  end

  assign id_o  = id_q;
  assign fin_o = fin_q;

endmodule

FILE: rtl/resource_constrained_list_scheduler.sv
// Flow: an accepted operation makes a dependency ring pass, then a free-table ring pass, then a
//   write-back, and then raises the done strobe; a full store answers straight from idle, with no ring pass.
// A new operation is accepted only once the last one is written back; both ring rotations set the spacing.
// Reset: async active low; counts 1/1, latencies 1/2, free table refilled,
//   store empty. Results are a one-cycle strobe; the receiver cannot stall.
module resource_constrained_list_scheduler import rcls_pkg::*; #(
  parameter int unsigned MaxSteps = MaxStepsDef,
  parameter int unsigned MaxOps   = MaxOpsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                new_problem_i,
  input  logic                unit_kind_i,
  input  logic [IdW-1:0]      source_a_i,
  input  logic [IdW-1:0]      source_b_i,
  input  logic [IdW-1:0]      result_id_i,
  output logic                done_o,
  output logic [StepOutW-1:0] start_step_o,
  output logic [1:0]          status_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  localparam int unsigned SW   = $clog2(MaxSteps + 1);
  localparam int unsigned TW   = $clog2(MaxSteps);
  localparam int unsigned FinW = $clog2(MaxSteps + 64);
  localparam int unsigned KW   = $clog2(MaxOps);
  localparam int unsigned CW   = $clog2(MaxOps + 1);

  // configuration
  logic [CfgW-1:0] add_cnt_q, mul_cnt_q, add_lat_q, mul_lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_cnt_q <= CfgW'(1);
      mul_cnt_q <= CfgW'(1);
      add_lat_q <= CfgW'(1);
      mul_lat_q <= CfgW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ADD_CNT: add_cnt_q <= cfg_wdata_i;
        CFG_MUL_CNT: mul_cnt_q <= cfg_wdata_i;
        CFG_ADD_LAT: add_lat_q <= cfg_wdata_i;
        CFG_MUL_LAT: mul_lat_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  seq_state_e state_q, state_d;

  logic            kind_q;
  logic [IdW-1:0]  src_a_q, src_b_q, res_q;
  logic [CfgW-1:0] lat_q;
  logic [CW-1:0]   cnt_q;
  logic [KW-1:0]   k_q;
  logic [TW-1:0]   t_q;
  logic [FinW-1:0] dep_q, end_q;
  logic [SW-1:0]   start_q;
  logic            found_q, ok_q;
  logic            done_q;
  logic [StepOutW-1:0] step_out_q;
  sched_status_e   status_q;

  logic accept, full, refill, op_shift, step_shift, wb;

  assign accept = start && (state_q == S_IDLE);
  assign full   = !new_problem_i && (cnt_q == CW'(MaxOps));
  assign refill = accept && new_problem_i;

  always_comb begin
    state_d    = state_q;
    op_shift   = 1'b0;
    step_shift = 1'b0;
    wb         = 1'b0;
    unique case (state_q)
      S_IDLE: if (accept && !full) state_d = S_DEP;
      S_DEP: begin
        op_shift = 1'b1;
        if (k_q == KW'(MaxOps - 1)) state_d = S_SRCH;
      end
      S_SRCH: begin
        step_shift = 1'b1;
        if (t_q == TW'(MaxSteps - 1)) state_d = S_WB;
      end
      S_WB: begin
        wb      = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign busy = (state_q != S_IDLE);

  // operation store ring: cell 0 is the head, data moves towards it
  logic [IdW-1:0]  op_id  [MaxOps];
  logic [FinW-1:0] op_fin [MaxOps];
  logic [FinW-1:0] wb_fin;

  for (genvar i = 0; i < MaxOps; i++) begin : g_op
    localparam int unsigned Nx = (i + 1) % MaxOps;
    rcls_op_cell #(.FinW(FinW)) u_op (
      .clk_i,
      .shift_i   (op_shift),
      .wr_i      (wb && (cnt_q == CW'(i))),
      .nbr_id_i  (op_id[Nx]),
      .nbr_fin_i (op_fin[Nx]),
      .wr_id_i   (res_q),
      .wr_fin_i  (wb_fin),
      .id_o      (op_id[i]),
      .fin_o     (op_fin[i])
    );
  end

  // free table ring; the head is updated on its way back round
  free_pair_t step_free [MaxSteps];
  free_pair_t head_mod;

  for (genvar i = 0; i < MaxSteps; i++) begin : g_step
    free_pair_t nbr;
    if (i == MaxSteps - 1) begin : g_last
      assign nbr = head_mod;
    end else begin : g_mid
      assign nbr = step_free[i + 1];
    end
    rcls_step_cell u_step (
      .clk_i,
      .rst_ni,
      .refill_i  (refill),
      .add_cnt_i (add_cnt_q),
      .mul_cnt_i (mul_cnt_q),
      .shift_i   (step_shift),
      .nbr_i     (nbr),
      .free_o    (step_free[i])
    );
  end

  // dependency match at head of store ring
  logic dep_hit;
  assign dep_hit = (CW'(k_q) < cnt_q)
                && ((op_id[0] == src_a_q) || (op_id[0] == src_b_q))
                && (op_fin[0] > dep_q);

  // search and reservation at head of free ring
  logic signed [FreeW-1:0] head_free;
  logic            cand, ok_now, reserve;
  logic [FinW-1:0] t_end, end_now;

  assign head_free = kind_q ? step_free[0].mul_free : step_free[0].add_free;
  assign cand      = !found_q && (FinW'(t_q) >= dep_q) && (head_free > 8'sd0);
  assign t_end     = FinW'(t_q) + FinW'(lat_q);
  assign end_now   = cand ? t_end : end_q;
  assign ok_now    = cand ? (t_end <= FinW'(MaxSteps)) : ok_q;
  assign reserve   = (cand || found_q) && ok_now && (FinW'(t_q) < end_now);
  assign head_mod  = reserve ? take_unit(step_free[0], kind_q) : step_free[0];

  // unfound start reads as the table size
  logic [SW-1:0] start_fin;
  assign start_fin = found_q ? start_q : SW'(MaxSteps);
  assign wb_fin    = FinW'(start_fin) + FinW'(lat_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (accept) begin
        if (new_problem_i) cnt_q <= '0;
        if (full) begin
          done_q     <= 1'b1;
          status_q   <= ST_FULL;
          step_out_q <= '0;
        end
        found_q <= 1'b0;
      end
      if (state_q == S_SRCH && cand) found_q <= 1'b1;
      if (wb) begin
        cnt_q      <= cnt_q + CW'(1);
        done_q     <= 1'b1;
        step_out_q <= found_q ? StepOutW'(start_q) : '0;
        if (!found_q)   status_q <= ST_NO_STEP;
        else if (!ok_q) status_q <= ST_NO_RES;
        else            status_q <= ST_OK;
      end
    end
  end

  // operation payload and scan registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= unit_kind_i;
      src_a_q <= source_a_i;
      src_b_q <= source_b_i;
      res_q   <= result_id_i;
      lat_q   <= unit_kind_i ? mul_lat_q : add_lat_q;
      k_q     <= '0;
      t_q     <= '0;
      dep_q   <= FinW'(1);
    end
    if (state_q == S_DEP) begin
      k_q <= k_q + KW'(1);
      if (dep_hit) dep_q <= op_fin[0];
    end
    if (state_q == S_SRCH) begin
      t_q <= t_q + TW'(1);
      if (cand) begin
        start_q <= SW'(t_q);
        end_q   <= t_end;
        ok_q    <= ok_now;
      end
    end
  end

  assign done_o       = done_q;
  assign start_step_o = step_out_q;
  assign status_o     = status_q;

endmodule

FILE: rtl/rcls_checker.sv
module rcls_checker import rcls_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [StepOutW-1:0] start_step_o,
  input logic [1:0]          status_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("transaction dropped");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("busy ended without result");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NO_STEP || status_o == ST_FULL)) |-> (start_step_o == '0))
    else $error("failed step not zero");

endmodule

bind resource_constrained_list_scheduler rcls_checker u_rcls_checker (.*);

FILE: tb/sv/sched_checker.sv
module sched_checker import rcls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic                new_problem_i,
  input  logic                unit_kind_i,
  input  logic [IdW-1:0]      source_a_i,
  input  logic [IdW-1:0]      source_b_i,
  input  logic [IdW-1:0]      result_id_i,
  input  logic                done_o,
  input  logic [StepOutW-1:0] start_step_o,
  input  logic [1:0]          status_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  output int                  mismatches,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [StepOutW-1:0] step;
    sched_status_e       status;
  } slot_t;

  slot_t slots_q[$];

  logic [CfgW-1:0] add_cnt, mul_cnt, add_lat, mul_lat;
  logic signed [FreeW-1:0] free_tab [MaxStepsDef][2];
  logic [IdW-1:0] op_ids [MaxOpsDef];
  int unsigned    op_fin [MaxOpsDef];
  int unsigned    op_cnt;

  function automatic void refill();
    for (int s = 0; s < MaxStepsDef; s++) begin
      free_tab[s][0] = FreeW'(add_cnt);
      free_tab[s][1] = FreeW'(mul_cnt);
    end
  endfunction

  // schedule one operation against the shadow tables
  function automatic slot_t place_op(logic np, logic kind, logic [IdW-1:0] sa,
                                     logic [IdW-1:0] sb, logic [IdW-1:0] rid);
    slot_t r;
    int unsigned at, lat;
    lat = kind ? mul_lat : add_lat;
    at  = 1;
    if (np) begin
      op_cnt = 0;
      refill();
    end
    if (op_cnt >= MaxOpsDef) begin
      r.step   = '0;
      r.status = ST_FULL;
      return r;
    end
    for (int k = 0; k < op_cnt; k++)
      if ((op_ids[k] == sa || op_ids[k] == sb) && op_fin[k] > at) at = op_fin[k];
    if (at > MaxStepsDef) at = MaxStepsDef;
    while (at < MaxStepsDef && free_tab[at][kind] <= 0) at++;
    if (at >= MaxStepsDef) r.status = ST_NO_STEP;
    else if (at + lat > MaxStepsDef) r.status = ST_NO_RES;
    else begin
      r.status = ST_OK;
      for (int s = at; s < at + lat; s++)
        if (free_tab[s][kind] != FreeMin) free_tab[s][kind] = free_tab[s][kind] - 1;
    end
    op_ids[op_cnt] = rid;
    op_fin[op_cnt] = at + lat;
    op_cnt++;
    r.step = (r.status == ST_NO_STEP) ? '0 : StepOutW'(at);
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t sched_checker: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slot_t want;
    if (!rst_ni) begin
      add_cnt = 1;
      mul_cnt = 1;
      add_lat = 1;
      mul_lat = 2;
      op_cnt  = 0;
      refill();
      slots_q.delete();
      mismatches = 0;
    end else begin
      // result first: a transaction accepted at this edge answers later
      if (done_o) begin
        if (slots_q.size() == 0) report("unexpected result, status", status_o, 0);
        else begin
          want = slots_q.pop_front();
          if (start_step_o != want.step) report("start_step", start_step_o, want.step);
          if (status_o != want.status) report("status", status_o, want.status);
        end
      end
      if (start && !busy)
        slots_q = {slots_q, place_op(new_problem_i, unit_kind_i, source_a_i,
                                     source_b_i, result_id_i)};
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ADD_CNT: add_cnt = cfg_wdata_i;
          CFG_MUL_CNT: mul_cnt = cfg_wdata_i;
          CFG_ADD_LAT: add_lat = cfg_wdata_i;
          CFG_MUL_LAT: mul_lat = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending = slots_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import rcls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumOps    = 1850;
  localparam int IdleLimit = 4000;  // well above the length of one transaction

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic new_problem_i = 1'b0;
  logic unit_kind_i = 1'b0;
  logic [IdW-1:0] source_a_i = '0;
  logic [IdW-1:0] source_b_i = '0;
  logic [IdW-1:0] result_id_i = '0;
  logic done_o;
  logic [StepOutW-1:0] start_step_o;
  logic [1:0] status_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  int mismatches, pending;
  int idle_pct;      // sender gap probability in percent
  int sent;
  int idle_cycles;
  logic busy_mid;    // busy sampled mid-cycle, free of edge races

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  resource_constrained_list_scheduler dut (.*);

  sched_checker u_checker (.*);

  always @(negedge clk_i) busy_mid <= busy;

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy_mid) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_op(logic np, logic kind, logic [IdW-1:0] sa,
                         logic [IdW-1:0] sb, logic [IdW-1:0] rid);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    new_problem_i <= np;
    unit_kind_i   <= kind;
    source_a_i    <= sa;
    source_b_i    <= sb;
    result_id_i   <= rid;
    do @(posedge clk_i); while (busy_mid);
    sent++;
  endtask

  // every expected result in and the block idle
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CfgW-1:0] pick_count();
    case ($urandom_range(7))
      0: return CfgW'(0);
      1: return CfgW'(63);
      2, 3, 4, 5: return CfgW'($urandom_range(1, 3));
      default: return CfgW'($urandom_range(63));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_latency();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? CfgW'(0) : CfgW'(63);
      1: return CfgW'(32);
      2: return CfgW'(1);
      default: return CfgW'($urandom_range(1, 8));
    endcase
  endfunction

  // a fresh problem: a chain of operations mostly fed by earlier results
  task automatic run_problem(int len);
    logic [IdW-1:0] made[$];
    logic [IdW-1:0] sa, sb, rid;
    for (int i = 0; i < len; i++) begin
      sa  = (made.size() > 0 && $urandom_range(9) < 7) ?
            made[$urandom_range(made.size() - 1)] : IdW'($urandom);
      sb  = (made.size() > 0 && $urandom_range(9) < 6) ?
            made[$urandom_range(made.size() - 1)] : IdW'($urandom);
      rid = IdW'($urandom);
      // occasional stray restart mid-chain
      send_op(i == 0 || $urandom_range(40) == 0, 1'($urandom_range(1)), sa, sb, rid);
      made = {made, rid};
      // sender holds off until the block has answered everything
      if ($urandom_range(60) == 0) drain();
    end
  endtask

  initial begin
    idle_pct = 0;
    sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of ids, both kinds, dependencies, reset config
    send_op(1'b1, 1'b0, '0, '0, '0);
    send_op(1'b0, 1'b1, '1, '1, '1);
    send_op(1'b0, 1'b0, '0, '1, 10'd5);
    send_op(1'b0, 1'b1, 10'd5, 10'd5, 10'd6);
    send_op(1'b0, 1'b0, 10'd6, 10'h2AA, 10'h155);
    drain();

    // no adders at all: no free step, and its dependents follow
    write_reg(CFG_ADD_CNT, CfgW'(0));
    send_op(1'b1, 1'b0, 10'd1, 10'd2, 10'd3);
    send_op(1'b0, 1'b1, 10'd3, 10'd9, 10'd4);
    send_op(1'b0, 1'b1, 10'd7, 10'd8, 10'd9);
    drain();

    // long latencies: reservations past the table end, then no step
    write_reg(CFG_ADD_CNT, CfgW'(63));
    write_reg(CFG_MUL_CNT, CfgW'(63));
    write_reg(CFG_ADD_LAT, CfgW'(32));
    write_reg(CFG_MUL_LAT, CfgW'(63));
    send_op(1'b1, 1'b1, 10'd0, 10'd0, 10'd1);
    send_op(1'b0, 1'b1, 10'd1, 10'd0, 10'd2);
    send_op(1'b0, 1'b0, 10'd2, 10'd1, 10'd3);
    send_op(1'b0, 1'b0, 10'd3, 10'd3, 10'd4);
    drain();

    // zero latency for adds, and one multiplier per step
    write_reg(CFG_ADD_LAT, CfgW'(0));
    write_reg(CFG_MUL_CNT, CfgW'(1));
    write_reg(CFG_MUL_LAT, CfgW'(5));
    send_op(1'b1, 1'b0, 10'd0, 10'd0, 10'd7);
    send_op(1'b0, 1'b0, 10'd7, 10'd7, 10'd8);
    send_op(1'b0, 1'b1, 10'd8, 10'd0, 10'd9);
    send_op(1'b0, 1'b1, 10'd0, 10'd0, 10'd10);
    send_op(1'b0, 1'b1, 10'd0, 10'd0, 10'd11);

    // random phases, each with its own config and one of three idling modes
    for (int ph = 0; sent < NumOps; ph++) begin
      drain();
      write_reg(CFG_ADD_CNT, pick_count());
      write_reg(CFG_MUL_CNT, pick_count());
      write_reg(CFG_ADD_LAT, pick_latency());
      write_reg(CFG_MUL_LAT, pick_latency());
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 67;
        2: idle_pct = 0;
        default: idle_pct = 24;
      endcase
      for (int n = 0; n < 180 && sent < NumOps; ) begin
        int len;
        // some problems overrun the store to reach the full case
        len = ($urandom_range(9) == 0) ? $urandom_range(62, 75) : $urandom_range(1, 30);
        run_problem(len);
        n += len;
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
